// File: rtl/sru_pkg.sv
// shared types, operation codes and helper functions for the shift/rotate unit
// no dependencies; used by sru_core, shift_rotate_unit_with_flags_unit and tb
package sru_pkg;

	typedef enum logic [2:0] {
		OP_ASR  = 3'd0,
		OP_ASL  = 3'd1,
		OP_LSR  = 3'd2,
		OP_LSL  = 3'd3,
		OP_ROR  = 3'd4,
		OP_ROL  = 3'd5,
		OP_ROXR = 3'd6,
		OP_ROXL = 3'd7
	} op_t;

	localparam logic [1:0] SIZE_BYTE = 2'd0;
	localparam logic [1:0] SIZE_WORD = 2'd1;

	localparam int DATA_W   = 32;
	localparam int COUNT_W  = 6;
	localparam int FLAGS_W  = 4;
	localparam int ROX_STEPS = 7;

	typedef struct packed {
		logic [DATA_W-1:0]  value;
		logic [FLAGS_W-1:0] nzvc;
		logic               x;
	} sru_res_t;

	// operand width in bits; the unused size code behaves as long
	function automatic logic [COUNT_W-1:0] size_bits(input logic [1:0] size);
		logic [COUNT_W-1:0] n;
		case (size)
			SIZE_BYTE: n = 6'd8;
			SIZE_WORD: n = 6'd16;
			default:   n = 6'd32;
		endcase
		return n;
	endfunction

	function automatic logic [DATA_W-1:0] size_mask(input logic [1:0] size);
		logic [DATA_W-1:0] m;
		case (size)
			SIZE_BYTE: m = 32'h0000_00ff;
			SIZE_WORD: m = 32'h0000_ffff;
			default:   m = 32'hffff_ffff;
		endcase
		return m;
	endfunction

	// count modulo (size + 1) by repeated compare and subtract
	function automatic logic [COUNT_W-1:0] rox_count(input logic [COUNT_W-1:0] cnt,
			input logic [1:0] size);
		logic [COUNT_W-1:0] m;
		logic [COUNT_W-1:0] e;
		m = size_bits(size) + 6'd1;
		e = cnt;
		for (int i = 0; i < ROX_STEPS; i++) begin
			if (e >= m) begin
				e = e - m;
			end
		end
		return e;
	endfunction

endpackage

// File: rtl/shift_rotate_unit_with_flags_unit.sv
// top level: input register, shift/rotate datapath, result register, extend flag
// depends on sru_pkg and sru_core
//
// One request is taken per clock cycle while the input does not stall; it goes
// via the input register and the combinational core to the result register.
// While a result waits, one more request can still enter the input register;
// after that the input stalls until the result is taken. The sustained rate
// of one request per cycle is set by the combinational datapath between the
// input and result registers, and by the extend flag register, loaded with
// the result so the following request sees the updated X. X resets to zero.
module shift_rotate_unit_with_flags_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  req_type,
	input  logic [1:0]  operand_size,
	input  logic [5:0]  shift_count,
	input  logic [31:0] operand,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result_value,
	output logic [3:0]  flags_nzvc,
	output logic        extend_out
);

	logic                valid_s1;
	sru_pkg::op_t        op_s1;
	logic [1:0]          size_s1;
	logic [5:0]          count_s1;
	logic [31:0]         operand_s1;

	logic                out_valid_q;
	sru_pkg::sru_res_t   res_q;
	logic                x_q;

	sru_pkg::sru_res_t   res;
	logic                adv;

	// the result register frees up when empty or being taken
	assign adv      = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || adv;

	sru_core u_core (
		.op      (op_s1),
		.size    (size_s1),
		.count   (count_s1),
		.operand (operand_s1),
		.x_in    (x_q),
		.res     (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_s1      <= sru_pkg::op_t'(req_type);
			size_s1    <= operand_size;
			count_s1   <= shift_count;
			operand_s1 <= operand;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			x_q         <= 1'b0;
		end else begin
			if (adv) begin
				out_valid_q <= 1'b1;
				x_q         <= res.x;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			res_q <= res;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = res_q.value;
	assign flags_nzvc   = res_q.nzvc;
	assign extend_out   = res_q.x;

	// x only moves when a request completes
	a_x_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!adv |=> $stable(x_q))
		else $error("extend flag changed without a request completing");

	// the offered extend flag is the one the next request will use
	a_x_match: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (extend_out == x_q))
		else $error("extend output differs from extend flag register");

	// plain rotates never touch x
	a_rot_x: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (op_s1 == sru_pkg::OP_ROR || op_s1 == sru_pkg::OP_ROL)) |=> $stable(x_q))
		else $error("rotate changed the extend flag");

	// n and z agree with the sign-extended result
	a_nz: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((flags_nzvc[3] == result_value[31])
			&& (flags_nzvc[2] == (result_value == 32'b0))))
		else $error("n or z flag inconsistent with result");

	// an empty input register always takes a request
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> in_ready)
		else $error("input stalled while input register empty");

endmodule

// File: rtl/sru_core.sv
// combinational shift/rotate datapath with nzvc and extend flag generation
// depends on sru_pkg
module sru_core (
	input  sru_pkg::op_t                    op,
	input  logic [1:0]                      size,
	input  logic [sru_pkg::COUNT_W-1:0]     count,
	input  logic [sru_pkg::DATA_W-1:0]      operand,
	input  logic                            x_in,
	output sru_pkg::sru_res_t               res
);

	logic [5:0]  n;
	logic [31:0] mask;
	logic [31:0] v;
	logic [31:0] sx;
	logic        sbit;
	logic        cnz;
	logic        c_ge_n;
	logic        c_gt_n;
	logic [5:0]  cm1;
	logic [6:0]  cp1;

	logic [31:0] asr_sh;
	logic [31:0] asr_r;
	logic        asr_c;
	logic [63:0] lsl_w;
	logic        lsl_c;
	logic [31:0] hm;
	logic [31:0] vh;
	logic        asl_v;
	logic [31:0] lsr_r;
	logic        lsr_c;

	logic [31:0] rep;
	logic [4:0]  rot_e;
	logic [63:0] ror_w;
	logic [63:0] rol_w;

	logic [5:0]  rox_e;
	logic [5:0]  rox_k;
	logic [32:0] t;
	logic [65:0] u;
	logic [65:0] u_sh;
	logic [31:0] rox_r;
	logic        rox_x;

	logic [31:0] r;
	logic        cf;
	logic        vf;
	logic        xf;
	logic        nf;
	logic [31:0] rm;

	always_comb begin
		n      = sru_pkg::size_bits(size);
		mask   = sru_pkg::size_mask(size);
		v      = operand & mask;
		case (size)
			sru_pkg::SIZE_BYTE: sx = {{24{v[7]}}, v[7:0]};
			sru_pkg::SIZE_WORD: sx = {{16{v[15]}}, v[15:0]};
			default:            sx = v;
		endcase
		sbit   = sx[31];
		cnz    = (count != 6'd0);
		c_ge_n = (count >= n);
		c_gt_n = (count > n);
		cm1    = count - 6'd1;
		cp1    = {1'b0, count} + 7'd1;

		// arithmetic right: sign fill covers counts of the size and beyond
		// shift kept on its own so the mask cannot turn it into a logical shift
		asr_sh = $signed(sx) >>> count;
		asr_r  = asr_sh & mask;
		asr_c  = cm1[5] ? sbit : sx[cm1[4:0]];

		// left shifts: carry is the bit that lands just above the size
		lsl_w = {32'b0, v} << count;
		case (size)
			sru_pkg::SIZE_BYTE: lsl_c = lsl_w[8];
			sru_pkg::SIZE_WORD: lsl_c = lsl_w[16];
			default:            lsl_c = lsl_w[32];
		endcase
		// overflow when the top count+1 bits are not all equal; from a count of the size on, when any bit is set
		hm    = mask & ~(mask >> cp1);
		vh    = v & hm;
		asl_v = (vh != 32'b0) && ((vh != hm) || c_ge_n);

		lsr_r = v >> count;
		lsr_c = cm1[5] ? 1'b0 : v[cm1[4:0]];

		// plain rotates on a copy repeated across 32 bits
		case (size)
			sru_pkg::SIZE_BYTE: rep = {4{v[7:0]}};
			sru_pkg::SIZE_WORD: rep = {2{v[15:0]}};
			default:            rep = v;
		endcase
		rot_e = count[4:0] & n[4:0] - 5'd1;
		ror_w = {rep, rep} >> rot_e;
		rol_w = {rep, rep} << rot_e;

		// rotate through x as a right rotate of the size+1 bit value {x, v}
		rox_e = sru_pkg::rox_count(count, size);
		rox_k = (op == sru_pkg::OP_ROXL && rox_e != 6'd0) ? (n + 6'd1 - rox_e) : rox_e;
		case (size)
			sru_pkg::SIZE_BYTE: t = {24'b0, x_in, v[7:0]};
			sru_pkg::SIZE_WORD: t = {16'b0, x_in, v[15:0]};
			default:            t = {x_in, v};
		endcase
		case (size)
			sru_pkg::SIZE_BYTE: u = {48'b0, t[8:0], t[8:0]};
			sru_pkg::SIZE_WORD: u = {32'b0, t[16:0], t[16:0]};
			default:            u = {t, t};
		endcase
		u_sh  = u >> rox_k;
		rox_r = u_sh[31:0] & mask;
		case (size)
			sru_pkg::SIZE_BYTE: rox_x = u_sh[8];
			sru_pkg::SIZE_WORD: rox_x = u_sh[16];
			default:            rox_x = u_sh[32];
		endcase

		r  = v;
		cf = 1'b0;
		vf = 1'b0;
		xf = x_in;
		case (op)
			sru_pkg::OP_ASR: begin
				if (cnz) begin
					r  = asr_r;
					cf = asr_c;
					xf = asr_c;
				end
			end
			sru_pkg::OP_ASL, sru_pkg::OP_LSL: begin
				if (cnz) begin
					r  = lsl_w[31:0] & mask;
					cf = lsl_c;
					xf = lsl_c;
					vf = (op == sru_pkg::OP_ASL) ? asl_v : 1'b0;
				end
			end
			sru_pkg::OP_LSR: begin
				if (cnz) begin
					r  = c_gt_n ? 32'b0 : lsr_r;
					cf = lsr_c;
					xf = lsr_c;
				end
			end
			sru_pkg::OP_ROR: begin
				r = ror_w[31:0] & mask;
				if (cnz) begin
					case (size)
						sru_pkg::SIZE_BYTE: cf = r[7];
						sru_pkg::SIZE_WORD: cf = r[15];
						default:            cf = r[31];
					endcase
				end
			end
			sru_pkg::OP_ROL: begin
				r = rol_w[63:32] & mask;
				if (cnz) begin
					cf = r[0];
				end
			end
			default: begin
				// ROXR and ROXL; a zero effective count leaves {x, v} as it is
				r  = rox_r;
				xf = rox_x;
				cf = rox_x;
			end
		endcase

		rm = r & mask;
		case (size)
			sru_pkg::SIZE_BYTE: nf = rm[7];
			sru_pkg::SIZE_WORD: nf = rm[15];
			default:            nf = rm[31];
		endcase
		res.value = nf ? (rm | ~mask) : rm;
		res.nzvc  = {nf, (rm == 32'b0), vf, cf};
		res.x     = xf;
	end

endmodule

// File: tb/sv/tb.sv
// self-checking testbench for shift_rotate_unit_with_flags_unit
// depends on sru_pkg (operation codes, size codes, result struct) and the unit itself
// table-driven directed requests, then constrained-by-hand random ones, checked in order
module tb;
	import sru_pkg::*;

	localparam logic [1:0] SIZE_LONG  = 2'd2;
	localparam logic [1:0] SIZE_SPARE = 2'd3;
	localparam int RANDOM_REQUESTS = 800;
	localparam int CYCLE_LIMIT = 400000;
	localparam sru_res_t NO_RES = '0;

	typedef struct {
		op_t         op;
		logic [1:0]  size;
		logic [5:0]  cnt;
		logic [31:0] opd;
		bit          fixed;
		sru_res_t    want;
	} shift_req_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [2:0]  req_type;
	logic [1:0]  operand_size;
	logic [5:0]  shift_count;
	logic [31:0] operand;
	logic        out_valid;
	logic        out_ready;
	logic [31:0] result_value;
	logic [3:0]  flags_nzvc;
	logic        extend_out;

	sru_res_t    pending_results[$];
	logic        x_model = 1'b0;
	int unsigned mismatches = 0;
	int unsigned cycles = 0;

	// fixed rows carry a hand-worked result; the rest go through the predictor
	shift_req_t directed_rows [0:24] = '{
		'{OP_ROXR, SIZE_BYTE,  6'd0,  32'h0000_0000, 1'b1, '{32'h0000_0000, 4'b0100, 1'b0}},
		'{OP_ASR,  SIZE_LONG,  6'd63, 32'h8000_0000, 1'b1, '{32'hffff_ffff, 4'b1001, 1'b1}},
		'{OP_ROXL, SIZE_BYTE,  6'd0,  32'hffff_ff80, 1'b1, '{32'hffff_ff80, 4'b1001, 1'b1}},
		'{OP_LSL,  SIZE_BYTE,  6'd9,  32'h0000_00ff, 1'b1, '{32'h0000_0000, 4'b0100, 1'b0}},
		'{OP_LSL,  SIZE_BYTE,  6'd8,  32'h0000_0001, 1'b1, '{32'h0000_0000, 4'b0101, 1'b1}},
		'{OP_ASL,  SIZE_BYTE,  6'd1,  32'h0000_0040, 1'b1, '{32'hffff_ff80, 4'b1010, 1'b0}},
		'{OP_ASL,  SIZE_WORD,  6'd16, 32'h0000_0001, 1'b1, '{32'h0000_0000, 4'b0111, 1'b1}},
		'{OP_LSR,  SIZE_LONG,  6'd32, 32'h8000_0000, 1'b1, '{32'h0000_0000, 4'b0101, 1'b1}},
		'{OP_LSR,  SIZE_WORD,  6'd17, 32'h0000_ffff, 1'b1, '{32'h0000_0000, 4'b0100, 1'b0}},
		'{OP_ROR,  SIZE_BYTE,  6'd8,  32'h0000_0081, 1'b1, '{32'hffff_ff81, 4'b1001, 1'b0}},
		'{OP_ROL,  SIZE_WORD,  6'd1,  32'h0000_8000, 1'b1, '{32'h0000_0001, 4'b0001, 1'b0}},
		'{OP_ROXR, SIZE_BYTE,  6'd9,  32'h0000_0055, 1'b1, '{32'h0000_0055, 4'b0000, 1'b0}},
		'{OP_ASR,  SIZE_BYTE,  6'd3,  32'h0000_0090, 1'b0, NO_RES},
		'{OP_ASR,  SIZE_WORD,  6'd16, 32'h0000_7fff, 1'b0, NO_RES},
		'{OP_ASR,  SIZE_LONG,  6'd0,  32'hdead_beef, 1'b0, NO_RES},
		'{OP_ASL,  SIZE_LONG,  6'd31, 32'hffff_ffff, 1'b0, NO_RES},
		'{OP_LSR,  SIZE_BYTE,  6'd1,  32'hffff_ff01, 1'b0, NO_RES},
		'{OP_ROL,  SIZE_LONG,  6'd63, 32'h8000_0001, 1'b0, NO_RES},
		'{OP_ROR,  SIZE_LONG,  6'd31, 32'h1234_5678, 1'b0, NO_RES},
		'{OP_ROXL, SIZE_BYTE,  6'd1,  32'h0000_0080, 1'b0, NO_RES},
		'{OP_ROXR, SIZE_LONG,  6'd1,  32'h0000_0001, 1'b0, NO_RES},
		'{OP_ROXL, SIZE_WORD,  6'd17, 32'h0000_a5a5, 1'b0, NO_RES},
		'{OP_ROXR, SIZE_WORD,  6'd16, 32'h0000_8001, 1'b0, NO_RES},
		'{OP_ASR,  SIZE_SPARE, 6'd5,  32'hf000_0000, 1'b0, NO_RES},
		'{OP_LSL,  SIZE_SPARE, 6'd32, 32'h0000_0001, 1'b0, NO_RES}
	};

	shift_rotate_unit_with_flags_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.req_type     (req_type),
		.operand_size (operand_size),
		.shift_count  (shift_count),
		.operand      (operand),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.result_value (result_value),
		.flags_nzvc   (flags_nzvc),
		.extend_out   (extend_out)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic int unsigned width_of(input logic [1:0] size);
		return (size == SIZE_BYTE) ? 8 : (size == SIZE_WORD) ? 16 : 32;
	endfunction

	// value, flags and new extend bit for one request, given the extend bit before it
	function automatic sru_res_t shift_outcome(input op_t op, input logic [1:0] size,
			input logic [5:0] cnt, input logic [31:0] opd, input logic x_in);
		int unsigned n, c, e;
		logic [63:0] mask, v, r, top, ones;
		logic sgn, cf, vf, x, nf;
		sru_res_t res;
		n = width_of(size);
		c = cnt;
		mask = (64'd1 << n) - 64'd1;
		v = {32'd0, opd} & mask;
		sgn = v[n-1];
		r = v;
		cf = 1'b0;
		vf = 1'b0;
		x = x_in;
		case (op)
			OP_ASR: begin
				if (c != 0) begin
					if (c >= n) begin
						r = sgn ? mask : 64'd0;
						cf = sgn;
					end else begin
						r = (v >> c) | (sgn ? (mask & ~(mask >> c)) : 64'd0);
						cf = v[c-1];
					end
					x = cf;
				end
			end
			OP_ASL, OP_LSL: begin
				if (c != 0) begin
					if (c <= n) begin
						r = (v << c) & mask;
						cf = v[n-c];
					end else begin
						r = 64'd0;
						cf = 1'b0;
					end
					// overflow if the msb changes at any step of the shift
					if (op == OP_ASL) begin
						if (c < n) begin
							top = v >> (n - 1 - c);
							ones = (64'd1 << (c + 1)) - 64'd1;
							vf = (top != 64'd0) && (top != ones);
						end else begin
							vf = (v != 64'd0);
						end
					end
					x = cf;
				end
			end
			OP_LSR: begin
				if (c != 0) begin
					if (c <= n) begin
						r = v >> c;
						cf = v[c-1];
					end else begin
						r = 64'd0;
						cf = 1'b0;
					end
					x = cf;
				end
			end
			OP_ROR, OP_ROL: begin
				if (c != 0) begin
					e = c & (n - 1);
					if (e != 0) begin
						if (op == OP_ROR) begin
							r = ((v >> e) | (v << (n - e))) & mask;
						end else begin
							r = ((v << e) | (v >> (n - e))) & mask;
						end
					end
					cf = (op == OP_ROR) ? r[n-1] : r[0];
				end
			end
			OP_ROXR: begin
				e = c % (n + 1);
				if (e != 0) begin
					r = ((v >> e) | ({63'd0, x} << (n - e)) | (v << (n + 1 - e))) & mask;
					x = v[e-1];
				end
				cf = x;
			end
			default: begin
				e = c % (n + 1);
				if (e != 0) begin
					r = ((v << e) | ({63'd0, x} << (e - 1)) | (v >> (n + 1 - e))) & mask;
					x = v[n-e];
				end
				cf = x;
			end
		endcase
		r = r & mask;
		nf = r[n-1];
		res.value = nf ? (r[31:0] | ~mask[31:0]) : r[31:0];
		res.nzvc = {nf, r == 64'd0, vf, cf};
		res.x = x;
		return res;
	endfunction

	// holds the request until taken, then records what it should produce
	task automatic offer_request(input shift_req_t rq, input bit steady);
		sru_res_t outcome;
		bit taken;
		while (!steady && $urandom_range(0, 99) < 34) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		req_type <= rq.op;
		operand_size <= rq.size;
		shift_count <= rq.cnt;
		operand <= rq.opd;
		// ready is settled by mid-cycle and decides the coming edge
		do begin
			@(negedge clk);
			taken = in_ready;
			@(posedge clk);
		end while (!taken);
		outcome = shift_outcome(rq.op, rq.size, rq.cnt, rq.opd, x_model);
		x_model = outcome.x;
		pending_results.push_back(rq.fixed ? rq.want : outcome);
	endtask

	initial begin
		int idx;
		int unsigned n, pick;
		shift_req_t rq;
		arst_n = 1'b0;
		in_valid = 1'b0;
		req_type = '0;
		operand_size = '0;
		shift_count = '0;
		operand = '0;
		out_ready = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (idx = 0; idx < 25; idx++) begin
			offer_request(directed_rows[idx], 1'b0);
		end

		for (idx = 0; idx < RANDOM_REQUESTS; idx++) begin
			rq.op = op_t'($urandom_range(0, 7));
			pick = $urandom_range(0, 9);
			rq.size = (pick < 3) ? SIZE_BYTE : (pick < 6) ? SIZE_WORD :
				(pick < 9) ? SIZE_LONG : SIZE_SPARE;
			n = width_of(rq.size);
			// counts cluster around the size and the rotate-through-extend period
			case ($urandom_range(0, 3))
				0, 1: rq.cnt = 6'($urandom_range(0, 63));
				2: rq.cnt = 6'(n - 1 + $urandom_range(0, 2));
				default: rq.cnt = 6'((n + 1) * $urandom_range(0, 63 / (n + 1)));
			endcase
			if ($urandom_range(0, 4) == 4) begin
				case ($urandom_range(0, 3))
					0: rq.opd = 32'h0000_0000;
					1: rq.opd = 32'hffff_ffff;
					2: rq.opd = 32'h1 << (n - 1);
					default: rq.opd = 32'h0000_0001;
				endcase
			end else begin
				rq.opd = $urandom;
			end
			rq.fixed = 1'b0;
			rq.want = NO_RES;
			offer_request(rq, idx >= 300 && idx < 450);
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// result side: checks in order, stalls at random, and once holds off long enough to back up
	initial begin
		int unsigned seen;
		bit held;
		sru_res_t want;
		seen = 0;
		held = 1'b0;
		@(posedge arst_n);
		forever begin
			// outputs are settled by mid-cycle; a transfer here completes at the next edge
			@(negedge clk);
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$error("result with no request outstanding: %h %b %b",
						result_value, flags_nzvc, extend_out);
					mismatches++;
				end else begin
					want = pending_results.pop_front();
					if (result_value !== want.value) begin
						$error("result_value: expected %h, got %h", want.value, result_value);
						mismatches++;
					end
					if (flags_nzvc !== want.nzvc) begin
						$error("flags_nzvc: expected %b, got %b", want.nzvc, flags_nzvc);
						mismatches++;
					end
					if (extend_out !== want.x) begin
						$error("extend_out: expected %b, got %b", want.x, extend_out);
						mismatches++;
					end
				end
				seen++;
			end
			@(posedge clk);
			if (seen == 150 && !held) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (250) @(posedge clk);
			end else begin
				out_ready <= (seen >= 450 && seen < 600) || ($urandom_range(0, 99) >= 34);
			end
		end
	end

endmodule
